// File: src/sbfd_pkg.sv
// ----------------------------------------------------------------------------
// sbfd_pkg: shared types and constants of the SBUS frame decoder
// Frame geometry, register indexes, switch positions and the records
// passed between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package sbfd_pkg;

  localparam int unsigned FRAME_LENGTH = 25;
  localparam int unsigned NUM_CHAN     = 8;
  localparam int unsigned CHAN_W       = 11;
  localparam int unsigned OUT_W        = 12;
  localparam int unsigned KEY_W        = 10;
  localparam int unsigned DATA_BYTES   = (NUM_CHAN * CHAN_W + 7) / 8;
  localparam int unsigned CNT_W        = $clog2(FRAME_LENGTH + 2);
  localparam int unsigned DIDX_W       = $clog2(DATA_BYTES);

  localparam logic [7:0] SBUS_HEADER = 8'h0F;
  localparam logic [7:0] SBUS_FOOTER = 8'h00;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned S_TDATA_W = 8;
  localparam int unsigned M_TDATA_W = ((NUM_CHAN * OUT_W + KEY_W + 7) / 8) * 8;
  localparam int unsigned PADDR_W   = 4;

  typedef enum logic [1:0] {
    REG_CHANNEL_OFFSET = 2'd0,
    REG_SWITCH_MIN     = 2'd1,
    REG_SWITCH_MAX     = 2'd2,
    REG_DEAD_BAND      = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    POS_UP  = 2'd0,
    POS_MID = 2'd1,
    POS_DN  = 2'd2
  } pos_e;

  localparam int unsigned KEY_A_UP   = 0;
  localparam int unsigned KEY_A_DOWN = 1;
  localparam int unsigned KEY_A_MID  = 2;
  localparam int unsigned KEY_B_UP   = 3;
  localparam int unsigned KEY_B_DOWN = 4;
  localparam int unsigned KEY_C_UP   = 5;
  localparam int unsigned KEY_C_DOWN = 6;
  localparam int unsigned KEY_D_UP   = 7;
  localparam int unsigned KEY_D_DOWN = 8;
  localparam int unsigned KEY_D_MID  = 9;

  typedef struct packed {
    logic [CHAN_W-1:0]       channel_offset;
    logic signed [OUT_W-1:0] switch_min;
    logic signed [OUT_W-1:0] switch_max;
    logic [9:0]              dead_band;
  } cfg_t;

  typedef struct packed {
    logic                           ok;
    logic [DATA_BYTES-1:0][7:0]     data;
  } frame_rec_t;

endpackage

// File: src/sbfd_front.sv
// ----------------------------------------------------------------------------
// sbfd_front: burst capture
// Counts the bytes of a burst, keeps the channel bytes and checks header,
// footer and length; on line idle it hands a frame record to the queue.
// ----------------------------------------------------------------------------
module sbfd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 beat_i,
  input  logic                 idle_i,
  input  logic [7:0]           byte_i,
  output logic                 push_o,
  output sbfd_pkg::frame_rec_t rec_o
);
  import sbfd_pkg::*;

  logic [CNT_W-1:0]           count_q, count_d;
  logic                       hdr_ok_q, ftr_ok_q;
  logic [DATA_BYTES-1:0][7:0] data_q;
  logic [DIDX_W-1:0]          widx;
  logic                       in_data;

  assign widx    = DIDX_W'(count_q - CNT_W'(1));
  assign in_data = (count_q >= CNT_W'(1)) && (count_q <= CNT_W'(DATA_BYTES));

  always_comb begin
    count_d = count_q;
    if (beat_i && idle_i) begin
      count_d = '0;
    end else if (beat_i && (count_q <= CNT_W'(FRAME_LENGTH))) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat_i && !idle_i) begin
      if (count_q == '0) begin
        hdr_ok_q <= (byte_i == SBUS_HEADER);
      end
      if (count_q == CNT_W'(FRAME_LENGTH - 1)) begin
        ftr_ok_q <= (byte_i == SBUS_FOOTER);
      end
      if (in_data) begin
        data_q[widx] <= byte_i;
      end
    end
  end

  assign push_o   = beat_i && idle_i;
  assign rec_o.ok = (count_q == CNT_W'(FRAME_LENGTH)) && hdr_ok_q && ftr_ok_q;
  assign rec_o.data = data_q;

endmodule

// File: src/sbfd_queue.sv
// ----------------------------------------------------------------------------
// sbfd_queue: frame record queue
// A short first-in first-out store between burst capture and decoding.
// ----------------------------------------------------------------------------
module sbfd_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  sbfd_pkg::frame_rec_t rec_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output sbfd_pkg::frame_rec_t rec_o
);
  import sbfd_pkg::*;

  frame_rec_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wptr_q, rptr_q;
  logic [QCNT_W-1:0]   cnt_q;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rec_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= rec_i;
    end
  end

endmodule

// File: src/sbfd_back.sv
// ----------------------------------------------------------------------------
// sbfd_back: channel decode and switch events
// Unpacks the channels, removes the center offset, classes the switches
// and registers one result beat with its key events.
// ----------------------------------------------------------------------------
module sbfd_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  sbfd_pkg::cfg_t             cfg_i,
  input  logic                       empty_i,
  input  sbfd_pkg::frame_rec_t       rec_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       out_ok_o,
  output logic [sbfd_pkg::M_TDATA_W-1:0] out_data_o
);
  import sbfd_pkg::*;

  logic [DATA_BYTES*8-1:0]        bits;
  logic signed [OUT_W-1:0]        ch [NUM_CHAN];
  logic signed [OUT_W:0]          lo_thr, hi_thr;
  pos_e                           pos [4];
  pos_e                           prev_q [4];
  logic [KEY_W-1:0]               keys;
  logic [NUM_CHAN*OUT_W-1:0]      chans;
  logic                           out_valid_q;
  logic                           out_ok_q;
  logic [M_TDATA_W-1:0]           out_data_q;

  assign bits   = rec_i.data;
  assign lo_thr = {cfg_i.switch_min[OUT_W-1], cfg_i.switch_min}
                + $signed({3'b000, cfg_i.dead_band});
  assign hi_thr = {cfg_i.switch_max[OUT_W-1], cfg_i.switch_max}
                - $signed({3'b000, cfg_i.dead_band});

  always_comb begin
    for (int i = 0; i < NUM_CHAN; i++) begin
      ch[i] = $signed({1'b0, bits[CHAN_W*i +: CHAN_W]})
            - $signed({1'b0, cfg_i.channel_offset});
      chans[OUT_W*i +: OUT_W] = ch[i];
    end
    for (int s = 0; s < 4; s++) begin
      if ($signed({ch[4+s][OUT_W-1], ch[4+s]}) <= lo_thr) begin
        pos[s] = POS_UP;
      end else if ($signed({ch[4+s][OUT_W-1], ch[4+s]}) >= hi_thr) begin
        pos[s] = POS_DN;
      end else begin
        pos[s] = POS_MID;
      end
    end
  end

  always_comb begin
    keys = '0;
    if (prev_q[0] == POS_MID && pos[0] == POS_UP) begin
      keys[KEY_A_UP] = 1'b1;
    end else if (prev_q[0] == POS_MID && pos[0] == POS_DN) begin
      keys[KEY_A_DOWN] = 1'b1;
    end else if (pos[0] == POS_MID) begin
      keys[KEY_A_MID] = 1'b1;
    end
    if (prev_q[1] == POS_DN && pos[1] == POS_UP) begin
      keys[KEY_B_UP] = 1'b1;
    end else if (prev_q[1] == POS_UP && pos[1] == POS_DN) begin
      keys[KEY_B_DOWN] = 1'b1;
    end
    if (prev_q[2] == POS_DN && pos[2] == POS_UP) begin
      keys[KEY_C_UP] = 1'b1;
    end else if (prev_q[2] == POS_UP && pos[2] == POS_DN) begin
      keys[KEY_C_DOWN] = 1'b1;
    end
    if (prev_q[3] == POS_MID && pos[3] == POS_UP) begin
      keys[KEY_D_UP] = 1'b1;
    end else if (prev_q[3] == POS_MID && pos[3] == POS_DN) begin
      keys[KEY_D_DOWN] = 1'b1;
    end else if (pos[3] == POS_MID) begin
      keys[KEY_D_MID] = 1'b1;
    end
  end

  assign pop_o = !empty_i && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      prev_q[0]   <= POS_MID;
      prev_q[1]   <= POS_DN;
      prev_q[2]   <= POS_DN;
      prev_q[3]   <= POS_MID;
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o && rec_i.ok) begin
        for (int s = 0; s < 4; s++) begin
          prev_q[s] <= pos[s];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_ok_q <= rec_i.ok;
      if (rec_i.ok) begin
        out_data_q <= M_TDATA_W'({keys, chans});
      end else begin
        out_data_q <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_ok_o    = out_ok_q;
  assign out_data_o  = out_data_q;

endmodule

// File: src/sbus_frame_decoder_switch_events_top.sv
// ----------------------------------------------------------------------------
// sbus_frame_decoder_switch_events_top: SBUS frame decoder with key events
// Captures receiver bytes, validates each burst on line idle, decodes the
// eight channels and reports switch position changes as key events.
// ----------------------------------------------------------------------------
//  Channel   Direction  Fields (lowest bit up)
//  s_axis    in         tdata: rx_byte; tuser: action
//  m_axis    out        tdata: chan0..chan7, key_events, zero pad; tuser: frame_ok
//  apb       in/out     channel_offset, switch_min, switch_max, dead_band
//
//  One input beat is taken every cycle while the record queue has room.
//  A line-idle beat yields one result beat, registered first in the record
//  queue and then in the decoder output register.
//  Reset clears the byte count and the queue and sets the switch memory to its start positions.
//  A stalled output backs up the queue, which then stalls the input.
// ----------------------------------------------------------------------------
module sbus_frame_decoder_switch_events_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [sbfd_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [7:0] rx_byte
  input  logic                           s_axis_tuser,  // [0] action
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [95:0] chan0..chan7 (12 bits each), [105:96] key_events, rest zero
  output logic [sbfd_pkg::M_TDATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tuser,  // [0] frame_ok
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sbfd_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import sbfd_pkg::*;

  cfg_t       cfg_q;
  reg_idx_e   ridx;
  logic       wr_en;
  logic       beat;
  logic       push;
  logic       full;
  logic       empty;
  logic       pop;
  frame_rec_t rec_in, rec_out;

  assign pready = 1'b1;
  assign ridx   = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channel_offset <= 11'd1024;
      cfg_q.switch_min     <= -12'sd672;
      cfg_q.switch_max     <= 12'sd672;
      cfg_q.dead_band      <= 10'd100;
    end else if (wr_en) begin
      unique case (ridx)
        REG_CHANNEL_OFFSET: cfg_q.channel_offset <= pwdata[CHAN_W-1:0];
        REG_SWITCH_MIN:     cfg_q.switch_min     <= pwdata[OUT_W-1:0];
        REG_SWITCH_MAX:     cfg_q.switch_max     <= pwdata[OUT_W-1:0];
        REG_DEAD_BAND:      cfg_q.dead_band      <= pwdata[9:0];
        default:            cfg_q                <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_CHANNEL_OFFSET: prdata = {21'd0, cfg_q.channel_offset};
      REG_SWITCH_MIN:     prdata = {20'd0, cfg_q.switch_min};
      REG_SWITCH_MAX:     prdata = {20'd0, cfg_q.switch_max};
      REG_DEAD_BAND:      prdata = {22'd0, cfg_q.dead_band};
      default:            prdata = '0;
    endcase
  end

  assign s_axis_tready = !full;
  assign beat          = s_axis_tvalid && s_axis_tready;

  sbfd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (beat),
    .idle_i (s_axis_tuser),
    .byte_i (s_axis_tdata),
    .push_o (push),
    .rec_o  (rec_in)
  );

  sbfd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (rec_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rec_o   (rec_out)
  );

  sbfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .rec_i       (rec_out),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_ok_o    (m_axis_tuser),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// File: sim/sbfd_frame_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sbfd_frame_checker: frame decoder scoreboard for the SBUS switch decoder
// Watches the byte stream, the result stream and the register port, keeps
// its own copy of the burst buffer, the switch memory and the settings, and
// compares every result beat field by field with the oldest decoded frame.
// ----------------------------------------------------------------------------
module sbfd_frame_checker
  import sbfd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [7:0]           in_byte_i,
  input  logic                 in_idle_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [M_TDATA_W-1:0] out_data_i,
  input  logic                 out_ok_i,
  input  logic                 psel_i,
  input  logic                 penable_i,
  input  logic                 pwrite_i,
  input  logic                 pready_i,
  input  logic [PADDR_W-1:0]   paddr_i,
  input  logic [31:0]          pwdata_i,
  output int unsigned          err_cnt_o,
  output int unsigned          pending_o
);

  typedef struct packed {
    logic                            ok;
    logic [KEY_W-1:0]                keys;
    logic [NUM_CHAN-1:0][OUT_W-1:0]  chans;
  } decoded_frame_t;

  int             center_ofs;
  int             up_end;
  int             down_end;
  int             tolerance;
  int             burst_len;
  logic [7:0]     burst_bytes [FRAME_LENGTH];
  pos_e           last_pos [4];
  decoded_frame_t frames_due [$];
  int unsigned    err_total;

  function automatic pos_e switch_pos(input int v);
    if (v <= up_end + tolerance) begin
      return POS_UP;
    end
    if (v >= down_end - tolerance) begin
      return POS_DN;
    end
    return POS_MID;
  endfunction

  task automatic close_burst();
    decoded_frame_t    res;
    logic [87:0]       bits;
    int                vals [NUM_CHAN];
    pos_e              now_pos [4];
    logic              good;
    good = (burst_len == FRAME_LENGTH) && (burst_bytes[0] == SBUS_HEADER) &&
           (burst_bytes[FRAME_LENGTH-1] == SBUS_FOOTER);
    burst_len = 0;
    res = '0;
    if (good) begin
      for (int i = 0; i < 11; i++) begin
        bits[8*i +: 8] = burst_bytes[i+1];
      end
      for (int c = 0; c < NUM_CHAN; c++) begin
        vals[c] = int'(bits[CHAN_W*c +: CHAN_W]) - center_ofs;
        res.chans[c] = vals[c][OUT_W-1:0];
      end
      for (int k = 0; k < 4; k++) begin
        now_pos[k] = switch_pos(vals[4+k]);
      end
      if (last_pos[0] == POS_MID && now_pos[0] == POS_UP) begin
        res.keys[KEY_A_UP] = 1'b1;
      end else if (last_pos[0] == POS_MID && now_pos[0] == POS_DN) begin
        res.keys[KEY_A_DOWN] = 1'b1;
      end else if (now_pos[0] == POS_MID) begin
        res.keys[KEY_A_MID] = 1'b1;
      end
      if (last_pos[1] == POS_DN && now_pos[1] == POS_UP) begin
        res.keys[KEY_B_UP] = 1'b1;
      end else if (last_pos[1] == POS_UP && now_pos[1] == POS_DN) begin
        res.keys[KEY_B_DOWN] = 1'b1;
      end
      if (last_pos[2] == POS_DN && now_pos[2] == POS_UP) begin
        res.keys[KEY_C_UP] = 1'b1;
      end else if (last_pos[2] == POS_UP && now_pos[2] == POS_DN) begin
        res.keys[KEY_C_DOWN] = 1'b1;
      end
      if (last_pos[3] == POS_MID && now_pos[3] == POS_UP) begin
        res.keys[KEY_D_UP] = 1'b1;
      end else if (last_pos[3] == POS_MID && now_pos[3] == POS_DN) begin
        res.keys[KEY_D_DOWN] = 1'b1;
      end else if (now_pos[3] == POS_MID) begin
        res.keys[KEY_D_MID] = 1'b1;
      end
      for (int k = 0; k < 4; k++) begin
        last_pos[k] = now_pos[k];
      end
      res.ok = 1'b1;
    end
    frames_due.push_back(res);
  endtask

  task automatic check_result();
    decoded_frame_t   want;
    logic [OUT_W-1:0] got_ch;
    logic [KEY_W-1:0] got_keys;
    if (frames_due.size() == 0) begin
      $error("result beat with no frame pending");
      err_total++;
    end else begin
      want = frames_due.pop_front();
      if (out_ok_i !== want.ok) begin
        $error("frame_ok: expected %0d, got %0d", want.ok, out_ok_i);
        err_total++;
      end
      for (int c = 0; c < NUM_CHAN; c++) begin
        got_ch = out_data_i[OUT_W*c +: OUT_W];
        if (got_ch !== want.chans[c]) begin
          $error("chan%0d: expected %0d, got %0d", c, $signed(want.chans[c]),
                 $signed(got_ch));
          err_total++;
        end
      end
      got_keys = out_data_i[NUM_CHAN*OUT_W +: KEY_W];
      if (got_keys !== want.keys) begin
        $error("key_events: expected %h, got %h", want.keys, got_keys);
        err_total++;
      end
      if (out_data_i[M_TDATA_W-1:NUM_CHAN*OUT_W+KEY_W] !== '0) begin
        $error("tdata pad: expected 0, got %h",
               out_data_i[M_TDATA_W-1:NUM_CHAN*OUT_W+KEY_W]);
        err_total++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_ofs  = 1024;
      up_end      = -672;
      down_end    = 672;
      tolerance   = 100;
      burst_len   = 0;
      last_pos[0] = POS_MID;
      last_pos[1] = POS_DN;
      last_pos[2] = POS_DN;
      last_pos[3] = POS_MID;
      frames_due.delete();
      err_total   = 0;
      err_cnt_o   <= 0;
      pending_o   <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_idx_e'(paddr_i[3:2]))
          REG_CHANNEL_OFFSET: center_ofs = int'(pwdata_i[10:0]);
          REG_SWITCH_MIN:     up_end     = int'($signed(pwdata_i[11:0]));
          REG_SWITCH_MAX:     down_end   = int'($signed(pwdata_i[11:0]));
          REG_DEAD_BAND:      tolerance  = int'(pwdata_i[9:0]);
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        check_result();
      end
      if (in_valid_i && in_ready_i) begin
        if (in_idle_i) begin
          close_burst();
        end else begin
          if (burst_len < FRAME_LENGTH) begin
            burst_bytes[burst_len] = in_byte_i;
          end
          if (burst_len <= FRAME_LENGTH) begin
            burst_len++;
          end
        end
      end
      pending_o <= frames_due.size();
      err_cnt_o <= err_total;
    end
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the SBUS frame decoder with key events
// Sends directed bursts, then mostly well-formed random frames mixed with
// broken bursts, under several register settings and backpressure patterns,
// while a separate checker decodes every burst and compares the results.
// ----------------------------------------------------------------------------
module testbench;
  import sbfd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          SEG_BEATS   = 175;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  int unsigned frame_errors;
  int unsigned frames_pending;
  int unsigned cycle_cnt = 0;
  int          src_pct;
  int          snk_pct;
  int          hold_reqs = 0;
  int          hold_seen = 0;
  int          hold_left;
  int          beats_sent;
  int          cur_ofs;
  int          cur_min;
  int          cur_max;
  int          cur_db;
  logic [7:0]  burst_buf [$];

  sbus_frame_decoder_switch_events_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  sbfd_frame_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_i  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_idle_i   (s_axis_tuser),
    .out_valid_i (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_i  (m_axis_tdata),
    .out_ok_i    (m_axis_tuser),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .err_cnt_o   (frame_errors),
    .pending_o   (frames_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    m_axis_tready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = 400;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= snk_pct);
      end
    end
  end

  task automatic send_beat(input logic idle, input logic [7:0] data);
    while ($urandom_range(99) < src_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= idle;
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
  endtask

  task automatic drain_frames();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (frames_pending != 0);
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_regs(input int ofs, input int lo, input int hi, input int db);
    drain_frames();
    repeat (8) @(posedge clk_i);
    cur_ofs = ofs;
    cur_min = lo;
    cur_max = hi;
    cur_db  = db;
    apb_write(REG_CHANNEL_OFFSET, 32'(ofs));
    apb_write(REG_SWITCH_MIN, 32'(lo));
    apb_write(REG_SWITCH_MAX, 32'(hi));
    apb_write(REG_DEAD_BAND, 32'(db));
  endtask

  function automatic int clamp_raw(input int v);
    if (v < 0) begin
      return 0;
    end
    if (v > 2047) begin
      return 2047;
    end
    return v;
  endfunction

  function automatic int pick_raw();
    int jitter;
    jitter = int'($urandom_range(4)) - 2;
    case ($urandom_range(9))
      0: return 0;
      1: return 2047;
      2, 3: return clamp_raw(cur_ofs + cur_min + cur_db + jitter);
      4, 5: return clamp_raw(cur_ofs + cur_max - cur_db + jitter);
      6: return clamp_raw(cur_ofs + (cur_min + cur_max) / 2 + jitter);
      default: return int'($urandom_range(2047));
    endcase
  endfunction

  // fixed_raw below zero means a random value for each channel.
  task automatic fill_frame(input int fixed_raw);
    logic [87:0] bits;
    int          raw;
    burst_buf.delete();
    for (int c = 0; c < NUM_CHAN; c++) begin
      raw = (fixed_raw < 0) ? pick_raw() : fixed_raw;
      bits[CHAN_W*c +: CHAN_W] = raw[CHAN_W-1:0];
    end
    burst_buf.push_back(SBUS_HEADER);
    for (int i = 0; i < 11; i++) begin
      burst_buf.push_back(bits[8*i +: 8]);
    end
    for (int i = 12; i < FRAME_LENGTH - 1; i++) begin
      burst_buf.push_back(8'($urandom_range(255)));
    end
    burst_buf.push_back(SBUS_FOOTER);
  endtask

  task automatic send_burst();
    foreach (burst_buf[i]) begin
      send_beat(1'b0, burst_buf[i]);
    end
    send_beat(1'b1, 8'($urandom_range(255)));
  endtask

  task automatic random_burst();
    int kind;
    int n;
    kind = $urandom_range(99);
    fill_frame(-1);
    if (kind >= 75 && kind < 82) begin
      burst_buf[0] = burst_buf[0] ^ 8'($urandom_range(1, 255));
    end else if (kind >= 82 && kind < 88) begin
      burst_buf[FRAME_LENGTH-1] = 8'($urandom_range(1, 255));
    end else if (kind >= 88 && kind < 94) begin
      n = $urandom_range(FRAME_LENGTH - 1);
      while (burst_buf.size() > n) begin
        void'(burst_buf.pop_back());
      end
    end else if (kind >= 94) begin
      n = $urandom_range(1, 15);
      repeat (n) burst_buf.push_back(8'($urandom_range(255)));
    end
    send_burst();
  endtask

  initial begin
    int seg_start;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    beats_sent    = 0;
    src_pct       = 6;
    snk_pct       = 64;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int seg = 0; seg < 6; seg++) begin
      case (seg / 2)
        0: begin
          src_pct = 6;
          snk_pct = 64;
        end
        1: begin
          src_pct = 64;
          snk_pct = 6;
        end
        default: begin
          src_pct = 0;
          snk_pct = 0;
        end
      endcase
      case (seg)
        0: set_regs(1024, -672, 672, 100);
        1: set_regs(0, -2047, 2047, 0);
        2: set_regs(2047, 2047, -2047, 1023);
        default: set_regs($urandom_range(2047), int'($urandom_range(4094)) - 2047,
                          int'($urandom_range(4094)) - 2047, $urandom_range(1023));
      endcase
      if (seg == 0) begin
        send_beat(1'b1, 8'hFF);
        fill_frame(0);
        send_burst();
        fill_frame(2047);
        send_burst();
        fill_frame(cur_ofs);
        send_burst();
        fill_frame(-1);
        burst_buf.push_back(SBUS_FOOTER);
        send_burst();
        fill_frame(-1);
        void'(burst_buf.pop_back());
        send_burst();
        fill_frame(-1);
        burst_buf[0] = 8'hF0;
        send_burst();
        hold_reqs++;
        repeat (10) send_beat(1'b1, 8'($urandom_range(255)));
      end
      seg_start = beats_sent;
      while (beats_sent - seg_start < SEG_BEATS) begin
        random_burst();
      end
    end

    drain_frames();
    repeat (16) @(posedge clk_i);
    if (frame_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sbus_frame_decoder_switch_events_top.f
src/sbfd_pkg.sv
src/sbfd_front.sv
src/sbfd_queue.sv
src/sbfd_back.sv
src/sbus_frame_decoder_switch_events_top.sv
sim/sbfd_frame_checker.sv
sim/testbench.sv
